// ===== src/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants of the photon/ADC packet parser
// Holds the field widths, header bit positions, register indexes, the
// result and configuration structs and a saturating increment helper.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned NumPhotonChDef = 4;
  localparam int unsigned NumAdcChDef    = 4;
  localparam int unsigned WrapBitsDef    = 31;

  localparam int unsigned WordW    = 16;
  localparam int unsigned PktWords = 6;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned SrcW     = 5;
  localparam int unsigned ChW      = 2;
  localparam int unsigned MacroW   = 17;
  localparam int unsigned MacroLoW = 14;
  localparam int unsigned MacroHiW = MacroW - MacroLoW;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned MicroW   = 15;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CapW     = 25;
  localparam int unsigned AdcIdxW  = 3;
  localparam int unsigned AmpLanes = 4;

  // Header and word bit positions.
  localparam int unsigned HdrConvBit  = 3;
  localparam int unsigned HdrStartBit = 6;
  localparam int unsigned HdrOvflBit  = 7;
  localparam int unsigned AdcMarkBit  = 14;

  localparam logic [SrcW-1:0]   AdcSrc       = 5'd4;
  localparam logic [PhaseW-1:0] PhotonLenRaw = 3'd2;
  localparam logic [PhaseW-1:0] PhotonLenCnv = 3'd3;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCapacity  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAdcIdx0   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAdcIdx1   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAdcIdx2   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAdcIdx3   = 3'd5;

  localparam logic [CountW-1:0] ThresholdRst = 32'hFFFF_FFFF;
  localparam logic [CapW-1:0]   CapacityRst  = 25'd65536;

  typedef enum logic [1:0] {
    KindStored  = 2'd0,
    KindBeyond  = 2'd1,
    KindDiscard = 2'd2,
    KindAdc     = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [CountW-1:0]                 threshold;
    logic [CapW-1:0]                   capacity;
    logic [AmpLanes-1:0][AdcIdxW-1:0]  adc_idx;
  } cfg_t;

  typedef struct packed {
    logic                              done;
    logic [PktWords-1:0][WordW-1:0]    words;
  } frame_t;

  typedef struct packed {
    event_kind_e                       kind;
    logic [ChW-1:0]                    channel;
    logic [TimeW-1:0]                  time_tag;
    logic [MicroW-1:0]                 micro_time;
    logic                              micro_valid;
    logic [CountW-1:0]                 event_count;
    logic [AmpLanes-1:0][WordW-1:0]    amp;
  } result_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (&v) ? v : v + CountW'(1);
  endfunction

endpackage

// ===== src/ppp_ifs.sv =====
// ----------------------------------------------------------------------------
// ppp_ifs: channel interfaces of the photon/ADC packet parser
// Stream word channel, event channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface ppp_word_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] data_word;
  logic        chunk_end;

  modport source (output valid, action, data_word, chunk_end, input ready);
  modport sink   (input valid, action, data_word, chunk_end, output ready);
endinterface

interface ppp_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [1:0]  channel;
  logic [47:0] time_tag;
  logic [14:0] micro_time;
  logic        micro_valid;
  logic [31:0] event_count;
  logic [15:0] amp0;
  logic [15:0] amp1;
  logic [15:0] amp2;
  logic [15:0] amp3;

  modport source (output valid, event_kind, channel, time_tag, micro_time, micro_valid,
                  event_count, amp0, amp1, amp2, amp3, input ready);
  modport sink   (input valid, event_kind, channel, time_tag, micro_time, micro_valid,
                  event_count, amp0, amp1, amp2, amp3, output ready);
endinterface

interface ppp_cfg_if
  import ppp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ppp_framer.sv =====
// ----------------------------------------------------------------------------
// ppp_framer: packet framing of the stream words
// Tracks the word position inside the current packet, keeps the words seen
// so far and flags the word that completes a packet.
// ----------------------------------------------------------------------------
module ppp_framer
  import ppp_pkg::*;
#(
  parameter int unsigned NUM_PHOTON_CH = NumPhotonChDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             data_i,
  input  logic             clear_i,
  input  logic [WordW-1:0] word_i,
  input  logic             chunk_end_i,
  output frame_t           frame_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [WordW-1:0]  words_q [PktWords];

  logic              hdr_is_adc;
  logic              take_hdr;
  logic [SrcW-1:0]   src;
  logic              src_ok;
  logic [PhaseW-1:0] phase_inc;
  logic [PhaseW-1:0] pkt_len;
  logic              done;

  always_comb begin
    hdr_is_adc = (words_q[0][WordW-1 -: SrcW] == AdcSrc);
    src        = word_i[WordW-1 -: SrcW];
    src_ok     = (src < SrcW'(NUM_PHOTON_CH)) || (src == AdcSrc);
    // The second word of an ADC packet must carry its marker bit; if it
    // does not, the stream has slipped and the word is a new header.
    take_hdr   = (phase_q == '0) || (phase_q > PhaseW'(PktWords - 1)) ||
                 (hdr_is_adc && (phase_q == PhaseW'(1)) && !word_i[AdcMarkBit]);
    phase_inc  = phase_q + PhaseW'(1);
    pkt_len    = hdr_is_adc ? PhaseW'(PktWords) :
                 (words_q[0][HdrConvBit] ? PhotonLenCnv : PhotonLenRaw);
    done       = !take_hdr && (phase_inc == pkt_len);

    phase_d = phase_q;
    if (clear_i) begin
      phase_d = '0;
    end else if (data_i) begin
      if (take_hdr) begin
        phase_d = src_ok ? PhaseW'(1) : '0;
      end else if (done) begin
        phase_d = '0;
      end else begin
        phase_d = phase_inc;
      end
      if (chunk_end_i) begin
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PktWords; i++) begin
      if (data_i && ((take_hdr && src_ok && (i == 0)) ||
                     (!take_hdr && (phase_q == PhaseW'(i))))) begin
        words_q[i] <= word_i;
      end
    end
  end

  // The completing word is taken straight from the input.
  always_comb begin
    frame_o.done = data_i && done;
    for (int i = 0; i < PktWords; i++) begin
      frame_o.words[i] = (!take_hdr && (phase_q == PhaseW'(i))) ? word_i : words_q[i];
    end
  end

endmodule

// ===== src/ppp_event.sv =====
// ----------------------------------------------------------------------------
// ppp_event: event builder of the photon/ADC packet parser
// Holds the wrap, photon and dropped counters; each completed ADC packet or
// start-flagged photon packet gives one event with extended time, count, amps.
// ----------------------------------------------------------------------------
module ppp_event
  import ppp_pkg::*;
#(
  parameter int unsigned NUM_PHOTON_CH = NumPhotonChDef,
  parameter int unsigned NUM_ADC_CH    = NumAdcChDef,
  parameter int unsigned WRAP_BITS     = WrapBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    clear_i,
  input  frame_t  frame_i,
  input  cfg_t    cfg_i,
  output logic    push_o,
  output result_t result_o
);

  logic [CountW-1:0]    pcnt_q  [NUM_PHOTON_CH];
  logic [CountW-1:0]    dcnt_q  [NUM_PHOTON_CH];
  logic [WRAP_BITS-1:0] pwrap_q [NUM_PHOTON_CH];
  logic [WRAP_BITS-1:0] awrap_q;
  logic [MacroW-1:0]    last_macro_q;

  logic [WordW-1:0]     hdr;
  logic                 is_adc;
  logic [ChW-1:0]       ch;
  logic [MacroW-1:0]    macro;
  logic [CountW-1:0]    cnt, drop, cnt_new, drop_new;
  logic [WRAP_BITS-1:0] wrap, wrap_new, awrap_new;
  logic                 under, below_cap, start, wrap_step, adc_step;

  always_comb begin
    hdr    = frame_i.words[0];
    is_adc = (hdr[WordW-1 -: SrcW] == AdcSrc);
    ch     = hdr[WordW-SrcW +: ChW];
    macro  = {hdr[MacroHiW-1:0], frame_i.words[1][MacroLoW-1:0]};

    cnt  = '0;
    drop = '0;
    wrap = '0;
    for (int i = 0; i < NUM_PHOTON_CH; i++) begin
      if (ch == ChW'(i)) begin
        cnt  = pcnt_q[i];
        drop = dcnt_q[i];
        wrap = pwrap_q[i];
      end
    end

    under     = cnt < cfg_i.threshold;
    below_cap = cnt < CountW'(cfg_i.capacity);
    start     = hdr[HdrStartBit];
    // Below threshold, overflow marker with a zero macro advances the wrap counter.
    wrap_step = under && hdr[HdrOvflBit] && (macro == '0);
    wrap_new  = wrap + WRAP_BITS'(wrap_step);
    cnt_new   = sat_inc(cnt);
    drop_new  = sat_inc(drop);
    // ADC packets carry no overflow marker: a backward macro step is a wrap.
    adc_step  = macro < last_macro_q;
    awrap_new = awrap_q + WRAP_BITS'(adc_step);
  end

  always_comb begin
    result_o = '0;
    push_o   = 1'b0;
    if (is_adc) begin
      push_o            = frame_i.done;
      result_o.kind     = KindAdc;
      result_o.time_tag = TimeW'({awrap_new, macro});
      for (int c = 0; c < AmpLanes; c++) begin
        for (int k = 0; k < PktWords; k++) begin
          if ((c < NUM_ADC_CH) && (cfg_i.adc_idx[c] == AdcIdxW'(k))) begin
            result_o.amp[c] = frame_i.words[k];
          end
        end
      end
    end else if (under) begin
      push_o               = frame_i.done && start;
      result_o.kind        = below_cap ? KindStored : KindBeyond;
      result_o.channel     = ch;
      result_o.micro_valid = below_cap && hdr[HdrConvBit];
      result_o.micro_time  = result_o.micro_valid ? frame_i.words[2][MicroW-1:0] : '0;
      result_o.time_tag    = TimeW'({wrap_new, macro});
      result_o.event_count = cnt_new;
    end else begin
      push_o               = frame_i.done && start;
      result_o.kind        = KindDiscard;
      result_o.channel     = ch;
      result_o.event_count = drop_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PHOTON_CH; i++) begin
        pcnt_q[i]  <= '0;
        dcnt_q[i]  <= '0;
        pwrap_q[i] <= '0;
      end
      awrap_q      <= '0;
      last_macro_q <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < NUM_PHOTON_CH; i++) begin
        pcnt_q[i]  <= '0;
        dcnt_q[i]  <= '0;
        pwrap_q[i] <= '0;
      end
      awrap_q      <= '0;
      last_macro_q <= '0;
    end else if (frame_i.done) begin
      if (is_adc) begin
        awrap_q      <= awrap_new;
        last_macro_q <= macro;
      end else begin
        for (int i = 0; i < NUM_PHOTON_CH; i++) begin
          if (ch == ChW'(i)) begin
            if (under) begin
              pwrap_q[i] <= wrap_new;
              if (start) begin
                pcnt_q[i] <= cnt_new;
              end
            end else if (start) begin
              dcnt_q[i] <= drop_new;
            end
          end
        end
      end
    end
  end

endmodule

// ===== src/ppp_out_buf.sv =====
// ----------------------------------------------------------------------------
// ppp_out_buf: two-entry output buffer
// An output register and a skid register, so that a new event can be taken
// in while the previous one still waits on the sink.
// ----------------------------------------------------------------------------
module ppp_out_buf
  import ppp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    space_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t out_result_o
);

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  always_comb begin
    pop      = out_v_q && out_ready_i;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        out_d = result_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_d   = result_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = result_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o      = !skid_v_q;
  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;

endmodule

// ===== src/photon_adc_packet_parser.sv =====
// ----------------------------------------------------------------------------
// photon_adc_packet_parser: photon and ADC packet parser, top level
// Frames 16-bit stream words into photon and ADC packets and emits one event
// per completed ADC or start-flagged photon packet, timed unless discarded.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, sustained while the event sink keeps up.
// An event is computed from the last word of its packet and then registered.
// The two-entry output buffer sets the rate: a word is refused only while
// both the output and the skid register hold events.
// Reset: asynchronous, active low; clears framing, counters, wrap counts
// and the buffer, and loads the default configuration.
module photon_adc_packet_parser
  import ppp_pkg::*;
#(
  parameter int unsigned NUM_PHOTON_CH = NumPhotonChDef,
  parameter int unsigned NUM_ADC_CH    = NumAdcChDef,
  parameter int unsigned WRAP_BITS     = WrapBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppp_word_if.sink   in_i,
  ppp_event_if.source out_o,
  ppp_cfg_if.sink    cfg_i
);

  // Configuration registers. The port never stalls, so a write lands in
  // the cycle it is offered; indexes past the last register are dropped.
  logic [CountW-1:0]               thr_q;
  logic [CapW-1:0]                 cap_q;
  logic [AmpLanes-1:0][AdcIdxW-1:0] adc_idx_q;
  cfg_t                            cfg;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= ThresholdRst;
      cap_q        <= CapacityRst;
      adc_idx_q[0] <= AdcIdxW'(2);
      adc_idx_q[1] <= AdcIdxW'(3);
      adc_idx_q[2] <= AdcIdxW'(4);
      adc_idx_q[3] <= AdcIdxW'(5);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgThreshold: thr_q        <= cfg_i.data[CountW-1:0];
        CfgCapacity:  cap_q        <= cfg_i.data[CapW-1:0];
        CfgAdcIdx0:   adc_idx_q[0] <= cfg_i.data[AdcIdxW-1:0];
        CfgAdcIdx1:   adc_idx_q[1] <= cfg_i.data[AdcIdxW-1:0];
        CfgAdcIdx2:   adc_idx_q[2] <= cfg_i.data[AdcIdxW-1:0];
        CfgAdcIdx3:   adc_idx_q[3] <= cfg_i.data[AdcIdxW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.threshold = thr_q;
  assign cfg.capacity  = cap_q;
  assign cfg.adc_idx   = adc_idx_q;

  // A word is taken whenever the output buffer has room for one more event.
  // A clear action resets the run state and abandons any partial packet.
  logic    accept;
  logic    data_word_acc;
  logic    clear_acc;
  logic    space;
  frame_t  frame;
  logic    push;
  result_t result;
  result_t out_result;

  assign in_i.ready    = space;
  assign accept        = in_i.valid && space;
  assign data_word_acc = accept && !in_i.action;
  assign clear_acc     = accept && in_i.action;

  ppp_framer #(
    .NUM_PHOTON_CH (NUM_PHOTON_CH)
  ) u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_i      (data_word_acc),
    .clear_i     (clear_acc),
    .word_i      (in_i.data_word),
    .chunk_end_i (in_i.chunk_end),
    .frame_o     (frame)
  );

  // Counters, wrap extension and event payload; the event is computed in
  // the cycle the completing word arrives and registered in the buffer.
  ppp_event #(
    .NUM_PHOTON_CH (NUM_PHOTON_CH),
    .NUM_ADC_CH    (NUM_ADC_CH),
    .WRAP_BITS     (WRAP_BITS)
  ) u_event (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (clear_acc),
    .frame_i  (frame),
    .cfg_i    (cfg),
    .push_o   (push),
    .result_o (result)
  );

  ppp_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .result_i     (result),
    .space_o      (space),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_result_o (out_result)
  );

  assign out_o.event_kind  = out_result.kind;
  assign out_o.channel     = out_result.channel;
  assign out_o.time_tag    = out_result.time_tag;
  assign out_o.micro_time  = out_result.micro_time;
  assign out_o.micro_valid = out_result.micro_valid;
  assign out_o.event_count = out_result.event_count;
  assign out_o.amp0        = out_result.amp[0];
  assign out_o.amp1        = out_result.amp[1];
  assign out_o.amp2        = out_result.amp[2];
  assign out_o.amp3        = out_result.amp[3];

endmodule

// ===== src/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks of the photon/ADC packet parser
// Watches the event channel for stall behavior and for field combinations
// that no event may carry; bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker
  import ppp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [ChW-1:0]    out_channel,
  input logic [TimeW-1:0]  out_time_tag,
  input logic [MicroW-1:0] out_micro_time,
  input logic              out_micro_valid,
  input logic [CountW-1:0] out_event_count,
  input logic [WordW-1:0]  out_amp0,
  input logic [WordW-1:0]  out_amp1,
  input logic [WordW-1:0]  out_amp2,
  input logic [WordW-1:0]  out_amp3
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("event withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_kind, out_channel, out_time_tag,
                                         out_micro_time, out_micro_valid,
                                         out_event_count}))
    else $error("event payload changed while stalled");

  a_adc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KindAdc) |->
      (out_channel == '0) && (out_event_count == '0) && !out_micro_valid &&
      (out_micro_time == '0))
    else $error("ADC event carries photon fields");

  a_photon_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind != KindAdc) |->
      (out_amp0 == '0) && (out_amp1 == '0) && (out_amp2 == '0) && (out_amp3 == '0) &&
      (out_micro_valid || (out_micro_time == '0)) &&
      (!out_micro_valid || (out_kind == KindStored)))
    else $error("photon event carries amplitudes or a stray micro time");

  a_discard_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KindDiscard) |-> (out_time_tag == '0) &&
      (out_event_count != '0))
    else $error("discarded photon with time tag or zero drop count");

endmodule

bind photon_adc_packet_parser ppp_checker u_ppp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_kind        (out_o.event_kind),
  .out_channel     (out_o.channel),
  .out_time_tag    (out_o.time_tag),
  .out_micro_time  (out_o.micro_time),
  .out_micro_valid (out_o.micro_valid),
  .out_event_count (out_o.event_count),
  .out_amp0        (out_o.amp0),
  .out_amp1        (out_o.amp1),
  .out_amp2        (out_o.amp2),
  .out_amp3        (out_o.amp3)
);
